// File: src/rmod_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Running median detector package
// Shared types and fixed constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package rmod_pkg;

  localparam int DUR_W      = 16;
  localparam int DIST_W     = 15;
  localparam int SCALE_W    = 11;
  localparam int PROD_W     = DUR_W + SCALE_W;
  localparam int DIST_SHIFT = 12;

  // 0.034 / 2 cm per microsecond, times 16 for Q11.4, times 4096.
  localparam logic [SCALE_W-1:0] DIST_SCALE   = 11'd1114;
  // 20.0 cm in Q11.4.
  localparam logic [DIST_W-1:0]  THRESH_RESET = 15'd320;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_EMIT
  } rmod_state_t;

  typedef struct packed {
    logic capture;
    logic win_write;
    logic scan;
    logic emit;
  } rmod_cmd_t;

  typedef struct packed {
    logic hit;
  } rmod_sts_t;

endpackage
`default_nettype wire

// File: src/rmod_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Running median detector controller
// Sequences capture, window write, rank scan and result hand-off.
// ----------------------------------------------------------------------------
module rmod_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rmod_pkg::rmod_cmd_t     cmd,
  input  wire rmod_pkg::rmod_sts_t sts
);
  import rmod_pkg::*;

  rmod_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.win_write = 1'b1;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // The output register is free, or is emptied at this same edge.
        if (!out_valid_r || !out_stall) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: src/rmod_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Running median detector datapath
// Distance scaling, the ring window, the rank scan and the output register.
// ----------------------------------------------------------------------------
module rmod_dp #(
  parameter int WINDOW_SIZE = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [rmod_pkg::DUR_W-1:0]    in_echo_duration_us,
  input  wire logic                          cfg_wr_en,
  input  wire logic [rmod_pkg::DIST_W-1:0]   cfg_wr_data,
  input  wire rmod_pkg::rmod_cmd_t           cmd,
  output rmod_pkg::rmod_sts_t                sts,
  output logic [rmod_pkg::DIST_W-1:0]        out_median_distance,
  output logic                               out_obstacle,
  output logic                               out_drive_action
);
  import rmod_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_SIZE);
  localparam logic [SLOT_W:0]   SIZE_EXT  = (SLOT_W + 1)'(WINDOW_SIZE);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SIZE - 1);
  localparam logic [SLOT_W-1:0] MID_RANK  = SLOT_W'(WINDOW_SIZE / 2);

  logic [PROD_W-1:0] prod_r;
  logic [DIST_W-1:0] win_r [WINDOW_SIZE];
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] cand_r;
  logic [DIST_W-1:0] thresh_r;
  logic [DIST_W-1:0] med_r;
  logic              obst_r;

  logic [SLOT_W-1:0] wr_idx;
  logic [DIST_W-1:0] new_dist;
  logic [DIST_W-1:0] cand_val;
  logic [SLOT_W-1:0] rank;

  assign new_dist = prod_r[DIST_SHIFT +: DIST_W];
  assign wr_idx   = ({1'b0, slot_r} >= SIZE_EXT) ? '0 : slot_r;
  assign cand_val = win_r[cand_r];

  // Stable rank: entries strictly smaller, plus equal entries at lower slots.
  always_comb begin
    rank = '0;
    for (int j = 0; j < WINDOW_SIZE; j++) begin
      if ((win_r[j] < cand_val) || ((win_r[j] == cand_val) && (SLOT_W'(j) < cand_r))) begin
        rank = rank + 1'b1;
      end
    end
  end

  assign sts.hit = (rank == MID_RANK);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      prod_r <= PROD_W'(in_echo_duration_us) * PROD_W'(DIST_SCALE);
    end
    if (cmd.emit) begin
      med_r  <= cand_val;
      obst_r <= (cand_val < thresh_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW_SIZE; k++) begin
        win_r[k] <= '0;
      end
      slot_r   <= '0;
      cand_r   <= '0;
      thresh_r <= THRESH_RESET;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      if (cmd.win_write) begin
        win_r[wr_idx] <= new_dist;
        slot_r        <= (wr_idx == LAST_SLOT) ? '0 : wr_idx + 1'b1;
        cand_r        <= '0;
      end else if (cmd.scan && !sts.hit) begin
        cand_r <= cand_r + 1'b1;
      end
    end
  end

  assign out_median_distance = med_r;
  assign out_obstacle        = obst_r;
  assign out_drive_action    = obst_r;

endmodule
`default_nettype wire

// File: src/running_median_obstacle_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Running median obstacle detector
// Turns echo pulse widths into distances and reports the running median.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction carries one echo pulse width in microseconds. The
// width is scaled to a Q11.4 centimeter distance and written into a ring
// window of WINDOW_SIZE entries. Each input gives exactly one output
// transaction: the window median, an obstacle flag (median strictly below
// the threshold register) and a drive action that equals the flag.
// The median is found by a rank scan: one window entry per cycle is compared
// against all entries at once until the entry of middle rank is found.
// An item goes through capture, window write, the scan and the emit step;
// the scan length, and any output stall in the emit step, set the throughput.
// Input is taken only while the block is idle; in_stall is high otherwise.
// The result sits in an output register, so a new input may be accepted
// while a result still waits. A stalled receiver holds the result stable and
// keeps the next result waiting in the controller after its scan is done.
// Reset clears the window to zero, the write slot to zero and sets the
// threshold to 20.0 cm; early medians therefore include those zeros.
// The threshold register is written whenever cfg_wr_en is high.
// ----------------------------------------------------------------------------
module running_median_obstacle_detector #(
  parameter int WINDOW_SIZE = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [rmod_pkg::DUR_W-1:0]  in_echo_duration_us,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [rmod_pkg::DIST_W-1:0]      out_median_distance,
  output logic                             out_obstacle,
  output logic                             out_drive_action,
  input  wire logic                        cfg_wr_en,
  input  wire logic [rmod_pkg::DIST_W-1:0] cfg_wr_data
);
  import rmod_pkg::*;

  // Commands from the controller and the scan status back from the datapath.
  rmod_cmd_t cmd;
  rmod_sts_t sts;

  rmod_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  rmod_dp #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_echo_duration_us (in_echo_duration_us),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_median_distance (out_median_distance),
    .out_obstacle        (out_obstacle),
    .out_drive_action    (out_drive_action)
  );

endmodule
`default_nettype wire

// File: src/rmod_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Running median detector checker
// Port-level checks on the detector, attached by a bind statement.
// ----------------------------------------------------------------------------
module rmod_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [14:0] out_median_distance,
  input wire logic        out_obstacle,
  input wire logic        out_drive_action
);

  // A result that is stalled stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result was withdrawn");

  // The drive action always follows the obstacle flag.
  a_drive_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive_action == out_obstacle)
    else $error("drive action differs from obstacle flag");

  // Distances never exceed the scaled value of the widest echo.
  a_med_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_median_distance <= 15'd17823)
    else $error("median distance out of range");

  // One transaction at a time: the block is busy after accepting one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a transaction is in flight");

endmodule

bind running_median_obstacle_detector rmod_checker u_rmod_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_median_distance (out_median_distance),
  .out_obstacle        (out_obstacle),
  .out_drive_action    (out_drive_action)
);
`default_nettype wire
